// ----- sv/two_axis_endstop_calibrate_and_position_unit_assert.svh -----
// Assertion macros shared by the antenna drive modules.
// Depends on nothing; included inside module bodies.
`ifndef TWO_AXIS_ENDSTOP_CALIBRATE_AND_POSITION_UNIT_ASSERT_SVH
`define TWO_AXIS_ENDSTOP_CALIBRATE_AND_POSITION_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TAE_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// Next-cycle implication.
`define TAE_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ----- sv/tae_pkg.sv -----
// Package of the two-axis antenna drive: payload types, codes and constants.
// Depends on nothing.
package tae_pkg;
   localparam int ReadingBits = 10;
   localparam int SpanBits    = 16;
   localparam int ResBits     = 16;

   localparam logic [1:0] DRIVE_STOP = 2'd0;
   localparam logic [1:0] DRIVE_ONE  = 2'd1;
   localparam logic [1:0] DRIVE_TWO  = 2'd2;

   localparam logic [1:0] MODE_UNCAL = 2'd0;
   localparam logic [1:0] MODE_CAL   = 2'd1;
   localparam logic [1:0] MODE_POS   = 2'd2;

   localparam logic [1:0] PHASE_DONE = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_TWO  = 2'd2;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [2:0] CSR_LOW_LIMIT = 3'd0;
   localparam logic [2:0] CSR_HIGH_LIMIT = 3'd1;
   localparam logic [2:0] CSR_STILL_TOL = 3'd2;
   localparam logic [2:0] CSR_AZ_SPAN = 3'd3;
   localparam logic [2:0] CSR_ALT_SPAN = 3'd4;

   localparam logic [ResBits-1:0] RES_SAT = '1;

   typedef struct packed {
      logic                   cmd;
      logic [ReadingBits-1:0] az_reading;
      logic [ReadingBits-1:0] alt_reading;
      logic signed [15:0]     az_target;
      logic signed [15:0]     alt_target;
   } req_type;

   typedef struct packed {
      logic [1:0]         az_drive;
      logic [1:0]         alt_drive;
      logic [1:0]         mode;
      logic [ResBits-1:0] az_resolution;
      logic [ResBits-1:0] alt_resolution;
      logic               cal_fault;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // take the request into the item register
      logic step;       // start or sample step on the held item
      logic div_start;  // start both dividers
      logic div_take;   // store the quotients as resolutions
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;   // the step just finished calibration
      logic div_done;
   } sts_type;
endpackage

// ----- sv/two_axis_endstop_calibrate_and_position_unit.sv -----
// A response follows each plain step; when calibration completes, it waits for the restoring
// division of both axes, run in parallel.
// Throughput: one item at a time; next request taken the cycle after the response transfer.
// Reset (synchronous, active high) restores register defaults, uncalibrated mode, stopped drives.
// Top level of the two-axis antenna drive: joins controller and datapath.
// Depends on tae_pkg, tae_ctrl, tae_dp.
module two_axis_endstop_calibrate_and_position_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tae_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import tae_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Configuration writes are always taken; the user must send them only while the block is idle (not enforced).
   assign csr_ready = 1'b1;

   // The controller owns the handshakes; the request transfer loads the item register.
   tae_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .cmd(cmd), .sts(sts)
   );

   // The datapath holds all axis state and the response, stable while stalled.
   tae_dp u_dp (
      .clock(clock), .reset(reset),
      .req_data(req_data), .rsp_data(rsp_data),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .sts(sts)
   );
endmodule

// ----- sv/tae_ctrl.sv -----
// Controller of the antenna drive: sequences load, step, division and reply.
// Depends on tae_pkg.
module tae_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tae_pkg::cmd_type cmd,
   input  tae_pkg::sts_type sts
);
   import tae_pkg::*;
   `include "two_axis_endstop_calibrate_and_position_unit_assert.svh"

   typedef enum logic [2:0] {S_IDLE, S_STEP, S_DIVGO, S_DIV, S_OUT} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TAE_ASSERT_IMP(a_valid_in_out, clock, reset, rsp_valid_ff, state_ff == S_OUT)
   `TAE_ASSERT_NEXT(a_load_step, clock, reset, cmd.load, state_ff == S_STEP)
   `TAE_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != S_IDLE, !cmd.load)
endmodule

// ----- sv/tae_div.sv -----
// Restoring divider, one quotient bit a cycle, with zero-divisor saturation.
// Depends on tae_pkg.
module tae_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tae_pkg::SpanBits-1:0]    dividend,
   input  logic [tae_pkg::ReadingBits-1:0] divisor,
   output logic                            done,
   output logic [tae_pkg::ResBits-1:0]     quotient
);
   import tae_pkg::*;
   localparam int CntBits = $clog2(SpanBits + 1);

   logic [SpanBits-1:0]    quo_ff, quo_in;
   logic [ReadingBits:0]   rem_ff, rem_in;
   logic [ReadingBits-1:0] den_ff, den_in;
   logic [CntBits-1:0]     cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic [ReadingBits:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[ReadingBits-1:0], quo_ff[SpanBits-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CntBits'(SpanBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[SpanBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SpanBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = !busy_ff;
   assign quotient = (den_ff == '0) ? RES_SAT : ResBits'(quo_ff);
endmodule

// ----- sv/tae_dp.sv -----
// Datapath of the antenna drive: axis state, calibration, on-off control.
// Depends on tae_pkg and tae_div.
module tae_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  tae_pkg::req_type             req_data,
   output tae_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_index,
   input  logic [15:0]                  csr_wdata,
   input  tae_pkg::cmd_type             cmd,
   output tae_pkg::sts_type             sts
);
   import tae_pkg::*;
   `include "two_axis_endstop_calibrate_and_position_unit_assert.svh"

   typedef logic [ReadingBits-1:0] rd_type;

   rd_type              low_ff, high_ff, tol_ff;
   logic [SpanBits-1:0] span_ff [2];
   req_type             item_ff;
   logic [1:0]          mode_ff, mode_in;
   logic [1:0]          phase_ff [2], phase_in [2];
   rd_type              prev_ff [2], prev_in [2];
   logic                seen_ff [4], seen_in [4];
   rd_type              ep_ff [4], ep_in [4];
   logic [1:0]          pm_ff [4], pm_in [4];
   logic [ResBits-1:0]  res_ff [2], res_in [2];
   logic [1:0]          drv_ff [2], drv_in [2];
   logic                need_ff, need_in;
   rd_type              rd [2];
   logic signed [15:0]  tgt [2];
   logic                div_done [2];
   logic [ResBits-1:0]  quo [2];
   rd_type              ep_gap [2];
   logic                fault;

   assign rd[0]  = item_ff.az_reading;
   assign rd[1]  = item_ff.alt_reading;
   assign tgt[0] = item_ff.az_target;
   assign tgt[1] = item_ff.alt_target;

   always_comb begin
      rd_type             diff, lo, hi;
      logic               still, hit;
      logic signed [17:0] err, res;
      logic [1:0]         up;
      diff    = '0;
      lo      = '0;
      hi      = '0;
      still   = 1'b0;
      hit     = 1'b0;
      err     = '0;
      res     = '0;
      up      = DRIVE_STOP;
      mode_in = mode_ff;
      need_in = need_ff;
      for (int a = 0; a < 2; a++) begin
         phase_in[a] = phase_ff[a];
         prev_in[a]  = prev_ff[a];
         res_in[a]   = res_ff[a];
         drv_in[a]   = drv_ff[a];
      end
      for (int i = 0; i < 4; i++) begin
         seen_in[i] = seen_ff[i];
         ep_in[i]   = ep_ff[i];
         pm_in[i]   = pm_ff[i];
      end
      if (cmd.step) begin
         need_in = 1'b0;
         if (item_ff.cmd == CMD_START) begin
            mode_in = MODE_CAL;
            for (int a = 0; a < 2; a++) begin
               prev_in[a]  = rd[a];
               phase_in[a] = PHASE_ONE;
               drv_in[a]   = DRIVE_ONE;
               res_in[a]   = '0;
            end
            for (int i = 0; i < 4; i++) begin
               seen_in[i] = 1'b0;
               ep_in[i]   = '0;
            end
         end else if (mode_ff == MODE_CAL) begin
            for (int a = 0; a < 2; a++) begin
               diff  = (rd[a] > prev_ff[a]) ? rd[a] - prev_ff[a] : prev_ff[a] - rd[a];
               still = diff < tol_ff;
               hit   = 1'b0;
               if (phase_ff[a] != PHASE_DONE) begin
                  if (rd[a] < low_ff && !seen_ff[2*a]) begin
                     seen_in[2*a] = still;
                     hit          = still;
                  end else if (rd[a] > high_ff && !seen_ff[2*a+1]) begin
                     seen_in[2*a+1] = still;
                     hit            = still;
                  end
               end
               prev_in[a] = rd[a];
               if (hit) begin
                  if (phase_ff[a] == PHASE_ONE) begin
                     ep_in[2*a]  = rd[a];
                     phase_in[a] = PHASE_TWO;
                     drv_in[a]   = DRIVE_TWO;
                  end else begin
                     ep_in[2*a+1] = rd[a];
                     phase_in[a]  = PHASE_DONE;
                     drv_in[a]    = DRIVE_STOP;
                  end
               end
            end
            if (phase_in[0] == PHASE_DONE && phase_in[1] == PHASE_DONE) begin
               for (int a = 0; a < 2; a++) begin
                  lo = ep_in[2*a];
                  hi = ep_in[2*a+1];
                  up = (a == 0) ? DRIVE_TWO : DRIVE_ONE;
                  if (lo < hi) begin
                     pm_in[2*a]   = up;
                     pm_in[2*a+1] = 2'd3 - up;
                  end else begin
                     pm_in[2*a]   = 2'd3 - up;
                     pm_in[2*a+1] = up;
                     ep_in[2*a]   = hi;
                     ep_in[2*a+1] = lo;
                  end
                  drv_in[a] = DRIVE_STOP;
               end
               mode_in = MODE_POS;
               need_in = 1'b1;
            end
         end else if (mode_ff == MODE_POS) begin
            for (int a = 0; a < 2; a++) begin
               err = 18'(tgt[a]) - 18'(signed'({1'b0, rd[a]}));
               res = 18'(signed'({1'b0, res_ff[a]}));
               if (err < res && err > -res) drv_in[a] = DRIVE_STOP;
               else if (err > res) drv_in[a] = pm_ff[2*a];
               else if (err < -res) drv_in[a] = pm_ff[2*a+1];
            end
         end
      end
      if (cmd.div_take) begin
         res_in[0] = quo[0];
         res_in[1] = quo[1];
      end
   end

   assign ep_gap[0] = ep_ff[1] - ep_ff[0];
   assign ep_gap[1] = ep_ff[3] - ep_ff[2];

   for (genvar g = 0; g < 2; g++) begin : g_div
      tae_div u_div (
         .clock(clock), .reset(reset), .start(cmd.div_start),
         .dividend(span_ff[g]), .divisor(ep_gap[g]),
         .done(div_done[g]), .quotient(quo[g])
      );
   end

   assign sts.need_div = need_ff;
   assign sts.div_done = div_done[0] && div_done[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= ReadingBits'(100);
         high_ff    <= ReadingBits'(800);
         tol_ff     <= ReadingBits'(10);
         span_ff[0] <= SpanBits'(18000);
         span_ff[1] <= SpanBits'(9000);
         mode_ff    <= MODE_UNCAL;
         need_ff    <= 1'b0;
         for (int a = 0; a < 2; a++) begin
            phase_ff[a] <= PHASE_DONE;
            prev_ff[a]  <= '0;
            res_ff[a]   <= '0;
            drv_ff[a]   <= DRIVE_STOP;
         end
         for (int i = 0; i < 4; i++) begin
            seen_ff[i] <= 1'b0;
            ep_ff[i]   <= '0;
            pm_ff[i]   <= DRIVE_STOP;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_LIMIT:  low_ff     <= csr_wdata[ReadingBits-1:0];
               CSR_HIGH_LIMIT: high_ff    <= csr_wdata[ReadingBits-1:0];
               CSR_STILL_TOL:  tol_ff     <= csr_wdata[ReadingBits-1:0];
               CSR_AZ_SPAN:    span_ff[0] <= csr_wdata;
               CSR_ALT_SPAN:   span_ff[1] <= csr_wdata;
               default: ;
            endcase
         end
         mode_ff <= mode_in;
         need_ff <= need_in;
         for (int a = 0; a < 2; a++) begin
            phase_ff[a] <= phase_in[a];
            prev_ff[a]  <= prev_in[a];
            res_ff[a]   <= res_in[a];
            drv_ff[a]   <= drv_in[a];
         end
         for (int i = 0; i < 4; i++) begin
            seen_ff[i] <= seen_in[i];
            ep_ff[i]   <= ep_in[i];
            pm_ff[i]   <= pm_in[i];
         end
      end
      if (cmd.load) item_ff <= req_data;
   end

   assign fault = (mode_ff == MODE_POS) && (ep_ff[0] == ep_ff[1] || ep_ff[2] == ep_ff[3]);

   assign rsp_data.az_drive       = drv_ff[0];
   assign rsp_data.alt_drive      = drv_ff[1];
   assign rsp_data.mode           = mode_ff;
   assign rsp_data.az_resolution  = res_ff[0];
   assign rsp_data.alt_resolution = res_ff[1];
   assign rsp_data.cal_fault      = fault;

   `TAE_ASSERT_IMP(a_pos_sorted, clock, reset, mode_ff == MODE_POS, ep_ff[0] <= ep_ff[1] && ep_ff[2] <= ep_ff[3])
   `TAE_ASSERT_IMP(a_cal_no_fault, clock, reset, mode_ff != MODE_POS, !fault)
   `TAE_ASSERT_NEXT(a_need_pos, clock, reset, need_in && cmd.step, mode_ff == MODE_POS)
endmodule

// ----- test/tb.sv -----
// Self-checking testbench of the two-axis antenna drive: stimulus, prediction and checking.
// Depends on tae_pkg and two_axis_endstop_calibrate_and_position_unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tae_pkg::*;

   localparam int CycleLimit = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   two_axis_endstop_calibrate_and_position_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: a copy of the register file and of the block's own state.
   logic [9:0]  lim_lo, lim_hi, tol;
   logic [15:0] span [2];
   logic [1:0]  run_mode;
   logic [1:0]  phase [2];
   logic [9:0]  last_rd [2];
   logic        seen [4];
   logic [9:0]  stop_pt [4];
   logic [1:0]  dir_code [4];
   logic [15:0] deadband [2];
   logic [1:0]  motor [2];

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      cycles = 0;
   int      send_idle_pct = 12;
   int      recv_idle_pct = 56;
   int      accepted = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic predictor_reset();
      lim_lo = 10'd100; lim_hi = 10'd800; tol = 10'd10;
      span[0] = 16'd18000; span[1] = 16'd9000;
      run_mode = MODE_UNCAL;
      for (int i = 0; i < 2; i++) begin
         phase[i] = PHASE_DONE; last_rd[i] = '0; deadband[i] = '0; motor[i] = DRIVE_STOP;
      end
      for (int i = 0; i < 4; i++) begin
         seen[i] = 1'b0; stop_pt[i] = '0; dir_code[i] = DRIVE_STOP;
      end
   endtask

   task automatic predictor_config(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
         CSR_LOW_LIMIT:  lim_lo = val[9:0];
         CSR_HIGH_LIMIT: lim_hi = val[9:0];
         CSR_STILL_TOL:  tol = val[9:0];
         CSR_AZ_SPAN:    span[0] = val;
         CSR_ALT_SPAN:   span[1] = val;
         default: ;
      endcase
   endtask

   // One calibration check of one axis: an end stop counts once the axis sits still past it.
   function automatic void calib_axis(input int a, input logic [9:0] cur);
      logic [9:0] diff;
      logic still, hit;
      diff = (cur > last_rd[a]) ? cur - last_rd[a] : last_rd[a] - cur;
      still = diff < tol;
      hit = 1'b0;
      if (phase[a] != PHASE_DONE) begin
         if (cur < lim_lo && !seen[2*a]) begin
            seen[2*a] = still; hit = still;
         end else if (cur > lim_hi && !seen[2*a+1]) begin
            seen[2*a+1] = still; hit = still;
         end
      end
      last_rd[a] = cur;
      if (hit) begin
         if (phase[a] == PHASE_ONE) begin
            stop_pt[2*a] = cur; phase[a] = PHASE_TWO; motor[a] = DRIVE_TWO;
         end else begin
            stop_pt[2*a+1] = cur; phase[a] = PHASE_DONE; motor[a] = DRIVE_STOP;
         end
      end
   endfunction

   function automatic void order_axis(input int a, input logic [1:0] up);
      logic [9:0] lo, hi;
      logic [31:0] q;
      lo = stop_pt[2*a]; hi = stop_pt[2*a+1];
      if (lo < hi) begin
         dir_code[2*a] = up; dir_code[2*a+1] = 2'd3 - up;
      end else begin
         dir_code[2*a] = 2'd3 - up; dir_code[2*a+1] = up;
         stop_pt[2*a] = hi; stop_pt[2*a+1] = lo;
         lo = stop_pt[2*a]; hi = stop_pt[2*a+1];
      end
      if (hi == lo) deadband[a] = RES_SAT;
      else begin
         q = 32'(span[a]) / 32'(hi - lo);
         deadband[a] = (q > 32'(RES_SAT)) ? RES_SAT : q[15:0];
      end
   endfunction

   function automatic void position(input int a, input logic signed [15:0] tgt,
                                    input logic [9:0] cur);
      int err, res;
      err = int'(tgt) - int'(cur);
      res = int'(deadband[a]);
      if (err < res && err > -res) motor[a] = DRIVE_STOP;
      else if (err > res) motor[a] = dir_code[2*a];
      else if (err < -res) motor[a] = dir_code[2*a+1];
   endfunction

   function automatic rsp_type drive_step(input req_type r);
      rsp_type o;
      if (r.cmd == CMD_START) begin
         run_mode = MODE_CAL;
         last_rd[0] = r.az_reading; last_rd[1] = r.alt_reading;
         for (int i = 0; i < 2; i++) begin
            phase[i] = PHASE_ONE; motor[i] = DRIVE_ONE; deadband[i] = '0;
         end
         for (int i = 0; i < 4; i++) begin
            seen[i] = 1'b0; stop_pt[i] = '0;
         end
      end else if (run_mode == MODE_CAL) begin
         calib_axis(0, r.az_reading);
         calib_axis(1, r.alt_reading);
         if (phase[0] == PHASE_DONE && phase[1] == PHASE_DONE) begin
            order_axis(0, DRIVE_TWO);
            order_axis(1, DRIVE_ONE);
            motor[0] = DRIVE_STOP; motor[1] = DRIVE_STOP;
            run_mode = MODE_POS;
         end
      end else if (run_mode == MODE_POS) begin
         position(0, r.az_target, r.az_reading);
         position(1, r.alt_target, r.alt_reading);
      end
      o.az_drive = motor[0];
      o.alt_drive = motor[1];
      o.mode = run_mode;
      o.az_resolution = deadband[0];
      o.alt_resolution = deadband[1];
      o.cal_fault = (run_mode == MODE_POS) &&
                    (stop_pt[0] == stop_pt[1] || stop_pt[2] == stop_pt[3]);
      return o;
   endfunction

   // Driver: offers the head of the pending queue, prediction made on transfer.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(drive_step(req_data));
            void'(pending_reqs.pop_front());
            accepted <= accepted + 1;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs[0];
            end else req_valid <= 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: compares every response transfer with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report("unexpected response", 0, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.az_drive != want.az_drive)
               report("az_drive", rsp_data.az_drive, want.az_drive);
            if (rsp_data.alt_drive != want.alt_drive)
               report("alt_drive", rsp_data.alt_drive, want.alt_drive);
            if (rsp_data.mode != want.mode) report("mode", rsp_data.mode, want.mode);
            if (rsp_data.az_resolution != want.az_resolution)
               report("az_resolution", rsp_data.az_resolution, want.az_resolution);
            if (rsp_data.alt_resolution != want.alt_resolution)
               report("alt_resolution", rsp_data.alt_resolution, want.alt_resolution);
            if (rsp_data.cal_fault != want.cal_fault)
               report("cal_fault", rsp_data.cal_fault, want.cal_fault);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_req(input logic c, input logic [9:0] az,
                                        input logic [9:0] alt,
                                        input logic [15:0] taz, input logic [15:0] talt);
      req_type r;
      r.cmd = c; r.az_reading = az; r.alt_reading = alt;
      r.az_target = taz; r.alt_target = talt;
      return r;
   endfunction

   function automatic logic [9:0] rand_rd();
      return 10'($urandom);
   endfunction

   // Waits until every queued item has been transferred and answered.
   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] val);
      csr_index <= idx; csr_wdata <= val; csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      predictor_config(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A well-formed calibration sweep, then positioning: each axis drifts to one stop, rests, then the other.
   task automatic queue_sweep(input logic first_low);
      logic [9:0] az, alt, a_lo, a_hi;
      int steps;
      a_lo = (lim_lo > 0) ? lim_lo - 1 : 10'd0;
      a_hi = (lim_hi < 1023) ? lim_hi + 1 : 10'd1023;
      az = 10'($urandom_range(a_lo, a_hi));
      alt = 10'($urandom_range(a_lo, a_hi));
      pending_reqs.push_back(make_req(CMD_START, az, alt, 16'($urandom), 16'($urandom)));
      steps = $urandom_range(3, 10);
      for (int s = 0; s < steps; s++) begin
         az = (s < steps / 2) == first_low ? 10'($urandom_range(0, a_lo))
                                           : 10'($urandom_range(a_hi, 1023));
         alt = (s < steps / 2) != first_low ? 10'($urandom_range(0, a_lo))
                                            : 10'($urandom_range(a_hi, 1023));
         pending_reqs.push_back(make_req(CMD_SAMPLE, az, alt, 16'($urandom), 16'($urandom)));
         pending_reqs.push_back(make_req(CMD_SAMPLE, az, alt, 16'($urandom), 16'($urandom)));
      end
      // Positioning with targets near the readings so deadband edges are met.
      for (int s = 0; s < $urandom_range(4, 20); s++) begin
         az = rand_rd(); alt = rand_rd();
         pending_reqs.push_back(make_req(CMD_SAMPLE, az, alt,
            ($urandom_range(3) == 0) ? 16'($urandom) :
               16'(int'(az) + int'(deadband[0]) * ($urandom_range(2) - 1)
                   + $urandom_range(4) - 2),
            ($urandom_range(3) == 0) ? 16'($urandom) :
               16'(int'(alt) + $urandom_range(60) - 30)));
      end
   endtask

   initial begin
      predictor_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: samples while uncalibrated, an equal-endpoint calibration with
      // extreme spans, then a clean one, with extreme fields in the first two.
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd1023, 10'd0, 16'h7fff, 16'h8000));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd0, 10'd1023, 16'h8000, 16'h7fff));
      drain();
      csr_write(CSR_AZ_SPAN, 16'd36000);
      csr_write(CSR_ALT_SPAN, 16'd1);
      csr_write(CSR_LOW_LIMIT, 16'd1023);
      csr_write(CSR_HIGH_LIMIT, 16'd0);
      csr_write(CSR_STILL_TOL, 16'd1023);
      csr_write(3'd7, 16'hffff);
      // Both limits cover every reading from 1 to 1022, so one reading may hit both stops: zero distance.
      pending_reqs.push_back(make_req(CMD_START, 10'd500, 10'd500, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd500, 10'd500, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd500, 10'd500, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd500, 10'd500, 16'h7fff, 16'h8000));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd0, 10'd1023, 16'h8000, 16'h7fff));
      drain();
      csr_write(CSR_LOW_LIMIT, 16'd100);
      csr_write(CSR_HIGH_LIMIT, 16'd800);
      csr_write(CSR_STILL_TOL, 16'd10);
      csr_write(CSR_AZ_SPAN, 16'd18000);
      csr_write(CSR_ALT_SPAN, 16'd9000);
      pending_reqs.push_back(make_req(CMD_START, 10'd400, 10'd400, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd50, 10'd900, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd52, 10'd902, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd950, 10'd20, 16'd0, 16'd0));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd951, 10'd21, 16'd0, 16'd0));
      drain();
      // Resolutions now known: error exactly at, just past and inside the deadband.
      for (int k = -1; k <= 1; k++)
         pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd500, 10'd500,
            16'(500 + int'(deadband[0]) + k), 16'(500 - int'(deadband[1]) + k)));
      pending_reqs.push_back(make_req(CMD_SAMPLE, 10'd500, 10'd500, 16'd500, 16'd500));
      drain();

      // Random part in three idling phases, with register settings changed in between.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 56 : 0;
         recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 12 : 0;
         while (accepted < 30 + (ph + 1) * 430) begin
            if ($urandom_range(9) == 0) begin
               for (int n = 0; n < 8; n++)
                  pending_reqs.push_back(make_req(1'($urandom), rand_rd(), rand_rd(),
                                                  16'($urandom), 16'($urandom)));
            end else queue_sweep(1'($urandom));
            drain();
            if ($urandom_range(5) == 0) begin
               csr_write(CSR_LOW_LIMIT, 16'($urandom_range(0, 300)));
               csr_write(CSR_HIGH_LIMIT, 16'($urandom_range(700, 1023)));
               csr_write(CSR_STILL_TOL, 16'($urandom_range(0, 1023)));
               csr_write(CSR_AZ_SPAN, 16'($urandom_range(1, 36000)));
               csr_write(CSR_ALT_SPAN, 16'($urandom_range(1, 36000)));
            end
         end
      end
      drain();
      if (mismatches == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/tae_pkg.sv
sv/tae_ctrl.sv
sv/tae_div.sv
sv/tae_dp.sv
sv/two_axis_endstop_calibrate_and_position_unit.sv
test/tb.sv
